// File: rtl/twsc_pkg.sv
// Package for the piecewise cubic tube waveshaper: widths, breakpoints,
// segment coefficients, transaction types and the Horner step helper.
// No dependencies.
`default_nettype none

package twsc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int IN_FRAC     = SAMPLE_BITS - 3;
  localparam int OUT_FRAC    = SAMPLE_BITS - 1;
  localparam int COEF_FRAC   = 16;
  localparam int COEF_W      = 18;
  localparam int ACC_W       = 20;
  localparam int PROD_W      = ACC_W + SAMPLE_BITS;
  localparam int CMP_W       = SAMPLE_BITS + COEF_FRAC;
  localparam int OUT_W       = ACC_W + OUT_FRAC;
  localparam int NUM_BP      = 7;
  localparam int NUM_SEG     = 6;
  localparam int NUM_COEF    = 4;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CAPACITY    = FIFO_DEPTH + 5;
  localparam int OCC_W       = $clog2(CAPACITY + 1);

  localparam logic signed [COEF_W-1:0] BP [NUM_BP] = '{
    COEF_W'(-64447), COEF_W'(-33225), COEF_W'(-13605), COEF_W'(-139),
    COEF_W'(13134),  COEF_W'(32809),  COEF_W'(58957)
  };

  localparam logic signed [ACC_W-1:0] FLAT_LOW  = ACC_W'(-21380);
  localparam logic signed [ACC_W-1:0] FLAT_HIGH = ACC_W'(46019);

  localparam logic signed [COEF_W-1:0] COEF [NUM_SEG][NUM_COEF] = '{
    '{COEF_W'(5118),   COEF_W'(15100),  COEF_W'(19471), COEF_W'(-11968)},
    '{COEF_W'(27697),  COEF_W'(49441),  COEF_W'(36881), COEF_W'(-9026)},
    '{COEF_W'(-51460), COEF_W'(6994),   COEF_W'(41136), COEF_W'(-8731)},
    '{COEF_W'(-51460), COEF_W'(6923),   COEF_W'(41134), COEF_W'(-8573)},
    '{COEF_W'(-7115),  COEF_W'(8106),   COEF_W'(38763), COEF_W'(-8573)},
    '{COEF_W'(21544),  COEF_W'(-58144), COEF_W'(10845), COEF_W'(-20201)}
  };

  localparam logic signed [PROD_W-1:0] IN_HALF  = PROD_W'(64'sd1 <<< (IN_FRAC - 1));
  localparam logic signed [OUT_W-1:0]  OUT_HALF = OUT_W'(64'sd1 <<< (COEF_FRAC - 1));
  localparam logic signed [OUT_W-1:0]  SAT_MAX  =
    OUT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [OUT_W-1:0]  SAT_MIN  = -SAT_MAX - OUT_W'(1);

  typedef enum logic [2:0] {
    CLS_SEG0 = 3'd0,
    CLS_SEG1 = 3'd1,
    CLS_SEG2 = 3'd2,
    CLS_SEG3 = 3'd3,
    CLS_SEG4 = 3'd4,
    CLS_SEG5 = 3'd5,
    CLS_LOW  = 3'd6,
    CLS_HIGH = 3'd7
  } cls_e;

  typedef struct packed {
    cls_e                          cls;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fifo_port_t;

  function automatic logic signed [COEF_W-1:0] coef(cls_e c, logic [1:0] j);
    logic signed [COEF_W-1:0] res;
    case (c) inside
      CLS_LOW, CLS_HIGH: res = '0;
      default:           res = COEF[c][j];
    endcase
    return res;
  endfunction

  // One Horner step: round the product half upwards, rescale and add the coefficient.
  function automatic logic signed [ACC_W-1:0] horner_add(logic signed [PROD_W-1:0] p,
                                                         logic signed [COEF_W-1:0] c);
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] shd;
    sum = p + IN_HALF;
    shd = sum >>> IN_FRAC;
    return ACC_W'(shd) + ACC_W'(c);
  endfunction

endpackage

`default_nettype wire

// File: rtl/twsc_front.sv
// Front end of the waveshaper: input register and breakpoint classifier.
// Depends on twsc_pkg; feeds the transaction queue.
`default_nettype none

module twsc_front (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [twsc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  wire logic                                    full_i,
  output twsc_pkg::fifo_port_t                         push_o
);

  logic                                    fv_q, fv_d;
  logic signed [twsc_pkg::SAMPLE_BITS-1:0] fs_q;
  logic                                    accept;
  logic                                    pushed;
  logic signed [twsc_pkg::CMP_W-1:0]       xs;
  twsc_pkg::cls_e                          cls;

  assign in_stall_o = fv_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign pushed     = fv_q && !full_i;
  assign fv_d       = accept || (fv_q && !pushed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fs_q <= sample_in_i;
    end
  end

  always_comb begin
    xs = twsc_pkg::CMP_W'(fs_q) <<< twsc_pkg::COEF_FRAC;
    if (xs < (twsc_pkg::CMP_W'(twsc_pkg::BP[0]) <<< twsc_pkg::IN_FRAC)) begin
      cls = twsc_pkg::CLS_LOW;
    end else begin
      cls = twsc_pkg::CLS_HIGH;
      for (int k = twsc_pkg::NUM_BP - 1; k >= 1; k--) begin
        if (xs <= (twsc_pkg::CMP_W'(twsc_pkg::BP[k]) <<< twsc_pkg::IN_FRAC)) begin
          cls = twsc_pkg::cls_e'(3'(k - 1));
        end
      end
    end
  end

  assign push_o.valid       = pushed;
  assign push_o.item.cls    = cls;
  assign push_o.item.sample = fs_q;

endmodule

`default_nettype wire

// File: rtl/twsc_fifo.sv
// Short transaction queue between the front end and the cubic evaluator.
// Depends on twsc_pkg.
`default_nettype none

module twsc_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire twsc_pkg::fifo_port_t push_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output twsc_pkg::fifo_port_t      head_o
);

  twsc_pkg::item_t                    mem_q [twsc_pkg::FIFO_DEPTH];
  logic [twsc_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [twsc_pkg::FIFO_PTR_W:0]      cnt_q, cnt_d;
  logic                               do_push, do_pop, empty;

  assign full_o  = cnt_q == (twsc_pkg::FIFO_PTR_W + 1)'(twsc_pkg::FIFO_DEPTH);
  assign empty   = cnt_q == '0;
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  assign head_o.valid = !empty;
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: rtl/twsc_back.sv
// Back end of the waveshaper: three-stage Horner pipeline, output scaling,
// inversion, saturation and the output register. Depends on twsc_pkg.
`default_nettype none

module twsc_back (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic                                    cfg_wdata_i,
  input  wire twsc_pkg::fifo_port_t                    head_i,
  output logic                                         pop_o,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed [twsc_pkg::SAMPLE_BITS-1:0]      sample_out_o
);

  typedef struct packed {
    twsc_pkg::cls_e                          cls;
    logic signed [twsc_pkg::SAMPLE_BITS-1:0] x;
    logic signed [twsc_pkg::PROD_W-1:0]      p;
  } stage_t;

  logic                                    invert_q;
  logic                                    adv;
  logic                                    v1_q, v2_q, v3_q, ov_q;
  stage_t                                  s1_q, s2_q, s3_q;
  stage_t                                  s1_d, s2_d, s3_d;
  logic signed [twsc_pkg::SAMPLE_BITS-1:0] out_q, out_d;
  logic signed [twsc_pkg::ACC_W-1:0]       acc1, acc2, acc3, acc_f;
  logic signed [twsc_pkg::OUT_W-1:0]       sh, rnd, sgn, sat;

  assign adv   = !ov_q || !out_stall_i;
  assign pop_o = adv && head_i.valid;

  always_comb begin
    s1_d.cls = head_i.item.cls;
    s1_d.x   = head_i.item.sample;
    s1_d.p   = twsc_pkg::PROD_W'(twsc_pkg::coef(head_i.item.cls, 2'd0))
             * twsc_pkg::PROD_W'(head_i.item.sample);

    acc1     = twsc_pkg::horner_add(s1_q.p, twsc_pkg::coef(s1_q.cls, 2'd1));
    s2_d.cls = s1_q.cls;
    s2_d.x   = s1_q.x;
    s2_d.p   = twsc_pkg::PROD_W'(acc1) * twsc_pkg::PROD_W'(s1_q.x);

    acc2     = twsc_pkg::horner_add(s2_q.p, twsc_pkg::coef(s2_q.cls, 2'd2));
    s3_d.cls = s2_q.cls;
    s3_d.x   = s2_q.x;
    s3_d.p   = twsc_pkg::PROD_W'(acc2) * twsc_pkg::PROD_W'(s2_q.x);

    acc3 = twsc_pkg::horner_add(s3_q.p, twsc_pkg::coef(s3_q.cls, 2'd3));
    case (s3_q.cls) inside
      twsc_pkg::CLS_LOW:  acc_f = twsc_pkg::FLAT_LOW;
      twsc_pkg::CLS_HIGH: acc_f = twsc_pkg::FLAT_HIGH;
      default:            acc_f = acc3;
    endcase

    sh  = twsc_pkg::OUT_W'(acc_f) <<< twsc_pkg::OUT_FRAC;
    rnd = (sh + twsc_pkg::OUT_HALF) >>> twsc_pkg::COEF_FRAC;
    sgn = invert_q ? -rnd : rnd;
    if (sgn > twsc_pkg::SAT_MAX) begin
      sat = twsc_pkg::SAT_MAX;
    end else if (sgn < twsc_pkg::SAT_MIN) begin
      sat = twsc_pkg::SAT_MIN;
    end else begin
      sat = sgn;
    end
    out_d = sat[twsc_pkg::SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        invert_q <= cfg_wdata_i;
      end
      if (adv) begin
        v1_q <= head_i.valid;
        v2_q <= v1_q;
        v3_q <= v2_q;
        ov_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      if (v3_q) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign sample_out_o = out_q;

endmodule

`default_nettype wire

// File: rtl/tube_waveshaper_piecewise_cubic_top.sv
// Top level of the piecewise cubic tube waveshaper: front end, queue and back end.
// Transactions pass the input register, queue, Horner stages and output register.
// Throughput: one transaction per cycle, set by the Horner pipeline, if not stalled.
// A four-entry queue lets the front end keep accepting while the output is stalled.
// Reset clears all valid flags, the queue and the invert register; no clearing pass.
// Depends on twsc_pkg, twsc_front, twsc_fifo and twsc_back.
`default_nettype none

module tube_waveshaper_piecewise_cubic_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic                                    cfg_wdata_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [twsc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed [twsc_pkg::SAMPLE_BITS-1:0]      sample_out_o
);

  twsc_pkg::fifo_port_t push, head;
  logic                 full, pop;

  twsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .full_i      (full),
    .push_o      (push)
  );

  twsc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  twsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire

// File: rtl/twsc_checker.sv
// Port-level checker for the waveshaper top level, with its bind statement.
// Depends on twsc_pkg and tube_waveshaper_piecewise_cubic_top.
`default_nettype none

module twsc_checker (
  input wire logic                                    clk_i,
  input wire logic                                    rst_ni,
  input wire logic                                    in_valid_i,
  input wire logic                                    in_stall_o,
  input wire logic                                    out_valid_o,
  input wire logic                                    out_stall_i,
  input wire logic signed [twsc_pkg::SAMPLE_BITS-1:0] sample_out_o
);

  logic [twsc_pkg::OCC_W-1:0] occ_q;
  logic                       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (in_acc && !out_acc) begin
      occ_q <= occ_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      occ_q <= occ_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output transaction changed or vanished");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != '0)
    else $error("output transaction without a matching input transaction");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= twsc_pkg::OCC_W'(twsc_pkg::CAPACITY))
    else $error("more transactions in flight than the pipeline can hold");

  a_no_early_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q < twsc_pkg::OCC_W'(twsc_pkg::FIFO_DEPTH + 1) |-> !in_stall_o)
    else $error("input stalled while the front end and queue still have room");

endmodule

bind tube_waveshaper_piecewise_cubic_top twsc_checker u_twsc_checker (.*);

`default_nettype wire

// File: bench/twsc_checker.sv
`timescale 1ns / 100ps
// Checker for the piecewise cubic tube waveshaper: it watches the invert register and both
// channels, predicts every shaped sample and compares it with what arrives.
// Depends on twsc_pkg for the sample width and the fixed-point fraction widths.
module tb_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic                                    cfg_wdata_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_i,
  input  logic signed [twsc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_stall_i,
  input  logic signed [twsc_pkg::SAMPLE_BITS-1:0] sample_out_i,
  output int                                      fail_count_o,
  output int                                      pending_o,
  output int                                      checked_o
);

  localparam int SB        = twsc_pkg::SAMPLE_BITS;
  localparam int IN_FRAC   = twsc_pkg::IN_FRAC;
  localparam int OUT_FRAC  = twsc_pkg::OUT_FRAC;
  localparam int COEF_FRAC = twsc_pkg::COEF_FRAC;
  localparam longint LEVEL_LOW_Q16  = -21380;
  localparam longint LEVEL_HIGH_Q16 = 46019;

  typedef struct packed {
    logic signed [SB-1:0] din;
    logic signed [SB-1:0] shaped;
  } shaped_due_t;

  shaped_due_t due_q[$];
  logic        invert_copy;
  int          fails;
  int          checked;

  function automatic longint knee_q16(int k);
    case (k)
      0:       return -64447;
      1:       return -33225;
      2:       return -13605;
      3:       return -139;
      4:       return 13134;
      5:       return 32809;
      default: return 58957;
    endcase
  endfunction

  // Cubic, square, linear and constant terms of one segment, 18 bits each.
  function automatic logic [71:0] segment_terms(int seg);
    case (seg)
      0:       return {18'sd5118, 18'sd15100, 18'sd19471, -18'sd11968};
      1:       return {18'sd27697, 18'sd49441, 18'sd36881, -18'sd9026};
      2:       return {-18'sd51460, 18'sd6994, 18'sd41136, -18'sd8731};
      3:       return {-18'sd51460, 18'sd6923, 18'sd41134, -18'sd8573};
      4:       return {-18'sd7115, 18'sd8106, 18'sd38763, -18'sd8573};
      default: return {18'sd21544, -18'sd58144, 18'sd10845, -18'sd20201};
    endcase
  endfunction

  function automatic longint term_of(logic [71:0] terms, int j);
    return longint'($signed(terms[71-18*j -: 18]));
  endfunction

  function automatic longint round_up_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [SB-1:0] shape_sample(logic signed [SB-1:0] x, logic invert);
    longint      xv;
    longint      acc;
    longint      r;
    longint      top;
    logic [71:0] terms;
    int          seg;
    xv  = longint'(x);
    seg = 6;
    if ((xv <<< COEF_FRAC) < (knee_q16(0) <<< IN_FRAC)) begin
      seg = -1;
    end else begin
      for (int k = 1; k < 7; k++) begin
        if (seg == 6 && (xv <<< COEF_FRAC) <= (knee_q16(k) <<< IN_FRAC)) seg = k - 1;
      end
    end
    if (seg < 0) begin
      acc = LEVEL_LOW_Q16;
    end else if (seg == 6) begin
      acc = LEVEL_HIGH_Q16;
    end else begin
      terms = segment_terms(seg);
      acc   = term_of(terms, 0);
      for (int j = 1; j < 4; j++) acc = round_up_shift(acc * xv, IN_FRAC) + term_of(terms, j);
    end
    r = round_up_shift(acc <<< OUT_FRAC, COEF_FRAC);
    if (invert) r = -r;
    top = (64'sd1 <<< (SB - 1)) - 1;
    if (r > top) r = top;
    if (r < -top - 1) r = -top - 1;
    return SB'(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shaped_due_t head;
    if (!rst_ni) begin
      due_q.delete();
      invert_copy = 1'b0;
      fails = 0;
      checked = 0;
      pending_o <= 0;
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        head.din    = sample_in_i;
        head.shaped = shape_sample(sample_in_i, invert_copy);
        due_q.push_back(head);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected transaction, sample_out %0d with none outstanding",
                   $time, sample_out_i);
        end else begin
          head = due_q.pop_front();
          checked++;
          if (sample_out_i !== head.shaped) begin
            fails++;
            $display("%0t: sample_out for input %0d: expected %0d, actual %0d",
                     $time, head.din, head.shaped, sample_out_i);
          end
        end
      end
      if (cfg_we_i) invert_copy = cfg_wdata_i;
      pending_o <= due_q.size();
      fail_count_o <= fails;
      checked_o <= checked;
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the piecewise cubic tube waveshaper: clock, reset, stimulus under
// several idling mixes, the invert setting and the verdict.
// Depends on twsc_pkg, tube_waveshaper_piecewise_cubic_top and tb_checker.
module tb_top;

  localparam int SB = twsc_pkg::SAMPLE_BITS;
  localparam int SAMPLES_PER_PHASE = 129;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SB-1:0] sample_in;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [SB-1:0] sample_out;
  int                   fail_count;
  int                   pending;
  int                   checked;
  int                   gap_pct;
  int                   stall_pct;
  int                   sent;
  int                   directed;

  tube_waveshaper_piecewise_cubic_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_in_i (sample_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sample_out_o(sample_out)
  );

  tb_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .sample_in_i (sample_in),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .sample_out_i(sample_out),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d shaped samples outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Largest input that still falls at or below breakpoint k.
  function automatic int knee_input(int k);
    case (k)
      0:       return -8056;
      1:       return -4154;
      2:       return -1701;
      3:       return -18;
      4:       return 1641;
      5:       return 4101;
      default: return 7369;
    endcase
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    int unsigned sel;
    int          v;
    sel = $urandom_range(99);
    if (sel < 60) begin
      v = int'($urandom_range(15800)) - 8300;
    end else if (sel < 75) begin
      v = knee_input($urandom_range(6)) + int'($urandom_range(6)) - 3;
    end else begin
      v = int'($urandom);
    end
    return SB'(v);
  endfunction

  task automatic send_sample(input logic signed [SB-1:0] s);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_invert(input logic value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid <= 1'b0;
    sample_in <= '0;
    out_stall <= 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_invert(1'b0);

    send_sample(SB'(-32768));
    send_sample(SB'(32767));
    send_sample(SB'(0));
    send_sample(SB'(-1));
    send_sample(SB'(1));
    send_sample(SB'(16'h5555));
    send_sample(SB'(16'haaaa));
    for (int k = 0; k < 7; k++) begin
      send_sample(SB'(knee_input(k)));
      send_sample(SB'(knee_input(k) + 1));
    end
    directed = sent;

    for (int p = 0; p < 8; p++) begin
      drain_results();
      set_invert(p % 2 == 1);
      case (p / 2)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 56;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 56;
        end
        default: begin
          gap_pct = 21;
          stall_pct = 21;
        end
      endcase
      repeat (SAMPLES_PER_PHASE) send_sample(pick_sample());
    end

    drain_results();
    stall_pct = 0;
    repeat (10) @(posedge clk);
    $display("Shaped %0d samples, %0d directed at the extremes and around every breakpoint,",
             sent, directed);
    $display("the rest random under four idling mixes, inversion off and on; %0d compared.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
